// ===== rtl/sraf_pkg.sv =====
`default_nettype none
package sraf_pkg;

    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam logic [15:0] TEMP_OFFSET_RESET = 16'd50;

    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_CHAR  = 2'd1;
    localparam logic [1:0] OP_SIGN  = 2'd2;
    localparam logic [1:0] OP_DIGIT = 2'd3;

    localparam logic [1:0] SEL_T = 2'd0;
    localparam logic [1:0] SEL_H = 2'd1;
    localparam logic [1:0] SEL_C = 2'd2;

    localparam logic [2:0] POS_LAST = 3'd4;

    typedef struct packed {
        logic       load;
        logic [1:0] op;
        logic [7:0] ch;
        logic [1:0] sel;
        logic [2:0] pos;
        logic       last;
        logic       nos;
    } t_cmd;

    function automatic logic [13:0] pow10(input logic [2:0] pos);
        logic [13:0] p;
        case (pos)
            3'd0:    p = 14'd10000;
            3'd1:    p = 14'd1000;
            3'd2:    p = 14'd100;
            3'd3:    p = 14'd10;
            default: p = 14'd1;
        endcase
        return p;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/sraf_ctrl.sv =====
`default_nettype none
module sraf_ctrl
    import sraf_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    input  wire logic       i_opcode,
    input  wire logic [7:0] i_sensor_letter,
    output t_cmd            o_cmd,
    output logic            o_busy
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_HDR   = 3'd1;
    localparam logic [2:0] S_SIGN  = 3'd2;
    localparam logic [2:0] S_DIGIT = 3'd3;
    localparam logic [2:0] S_TAIL  = 3'd4;

    logic [2:0] r_state, n_state;
    logic [2:0] r_cnt, n_cnt;
    logic [1:0] r_sel, n_sel;
    logic       r_all, n_all;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= 3'd0;
            r_sel   <= SEL_T;
            r_all   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_sel   <= n_sel;
            r_all   <= n_all;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_sel   = r_sel;
        n_all   = r_all;
        o_cmd   = '{load: 1'b0, op: OP_NONE, ch: CH_NUL, sel: r_sel,
                    pos: r_cnt, last: 1'b0, nos: 1'b0};
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = 3'd0;
                    if (!i_opcode) begin
                        n_state = S_HDR;
                        n_all   = 1'b1;
                        n_sel   = SEL_T;
                    end else if (i_sensor_letter == CH_T) begin
                        n_state = S_SIGN;
                        n_all   = 1'b0;
                        n_sel   = SEL_T;
                    end else if (i_sensor_letter == CH_H) begin
                        n_state = S_SIGN;
                        n_all   = 1'b0;
                        n_sel   = SEL_H;
                    end else if (i_sensor_letter == CH_C) begin
                        n_state = S_SIGN;
                        n_all   = 1'b0;
                        n_sel   = SEL_C;
                    end else begin
                        o_cmd.op   = OP_CHAR;
                        o_cmd.ch   = CH_NUL;
                        o_cmd.last = 1'b1;
                        o_cmd.nos  = 1'b1;
                    end
                end
            end
            S_HDR: begin
                o_cmd.op = OP_CHAR;
                case (r_cnt)
                    3'd0:    o_cmd.ch = CH_HASH;
                    3'd1:    o_cmd.ch = CH_A;
                    default: o_cmd.ch = CH_R;
                endcase
                if (r_cnt == 3'd2) begin
                    n_cnt   = 3'd0;
                    n_state = S_SIGN;
                end else begin
                    n_cnt = r_cnt + 3'd1;
                end
            end
            S_SIGN: begin
                o_cmd.op = OP_SIGN;
                n_cnt    = 3'd0;
                n_state  = S_DIGIT;
            end
            S_DIGIT: begin
                o_cmd.op   = OP_DIGIT;
                o_cmd.last = !r_all && (r_cnt == POS_LAST);
                if (r_cnt == POS_LAST) begin
                    n_cnt = 3'd0;
                    if (!r_all) begin
                        n_state = S_IDLE;
                    end else if (r_sel == SEL_C) begin
                        n_state = S_TAIL;
                    end else begin
                        n_sel   = r_sel + 2'd1;
                        n_state = S_SIGN;
                    end
                end else begin
                    n_cnt = r_cnt + 3'd1;
                end
            end
            S_TAIL: begin
                o_cmd.op   = OP_CHAR;
                o_cmd.ch   = CH_BANG;
                o_cmd.last = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/sraf_dp.sv =====
`default_nettype none
module sraf_dp
    import sraf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    input  wire logic        i_cfg_wr,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic [15:0] i_temp_sample,
    input  wire logic [15:0] i_humidity_sample,
    input  wire logic [15:0] i_co2_sample,
    output logic [7:0]       o_out_char,
    output logic             o_last_char,
    output logic             o_bad_letter,
    output logic             o_strobe
);

    logic [15:0] r_off;
    logic [15:0] r_t, r_h, r_c;
    logic [15:0] r_rem, n_rem;
    logic        r_started, n_started;
    logic        r_strobe, n_strobe;
    logic [7:0]  r_char, n_char;
    logic        r_last, n_last;
    logic        r_nos, n_nos;

    logic [13:0] pow;
    logic [16:0] thr;
    logic [16:0] sub;
    logic [3:0]  digit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off    <= TEMP_OFFSET_RESET;
            r_strobe <= 1'b0;
        end else begin
            if (i_cfg_wr) begin
                r_off <= i_cfg_data;
            end
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_t <= i_temp_sample;
            r_h <= i_humidity_sample;
            r_c <= i_co2_sample;
        end
        r_rem     <= n_rem;
        r_started <= n_started;
        r_char    <= n_char;
        r_last    <= n_last;
        r_nos     <= n_nos;
    end

    always_comb begin
        pow   = pow10(i_cmd.pos);
        digit = 4'd0;
        sub   = 17'd0;
        thr   = 17'd0;
        for (int k = 1; k <= 9; k++) begin
            thr = 17'(k) * {3'b000, pow};
            if ({1'b0, r_rem} >= thr) begin
                digit = 4'(k);
                sub   = thr;
            end
        end
    end

    always_comb begin
        n_rem     = r_rem;
        n_started = r_started;
        n_strobe  = 1'b0;
        n_char    = r_char;
        n_last    = i_cmd.last;
        n_nos     = i_cmd.nos;
        case (i_cmd.op)
            OP_CHAR: begin
                n_strobe = 1'b1;
                n_char   = i_cmd.ch;
            end
            OP_SIGN: begin
                n_strobe  = 1'b1;
                n_started = 1'b0;
                if (i_cmd.sel == SEL_T) begin
                    if (r_t <= r_off) begin
                        n_char = CH_MINUS;
                        n_rem  = r_off - r_t;
                    end else begin
                        n_char = CH_PLUS;
                        n_rem  = r_t - r_off;
                    end
                end else begin
                    n_char = CH_PLUS;
                    n_rem  = (i_cmd.sel == SEL_H) ? r_h : r_c;
                end
            end
            OP_DIGIT: begin
                n_rem     = r_rem - sub[15:0];
                n_char    = CH_ZERO + {4'd0, digit};
                n_strobe  = r_started || (digit != 4'd0) || (i_cmd.pos == POS_LAST);
                n_started = n_strobe;
            end
            default: begin
                n_strobe = 1'b0;
            end
        endcase
    end

    assign o_strobe     = r_strobe;
    assign o_out_char   = r_char;
    assign o_last_char  = r_last;
    assign o_bad_letter = r_nos;

endmodule
`default_nettype wire

// ===== rtl/sensor_reply_ascii_formatter_unit.sv =====
// The edge that takes start moves the controller out of idle; the first character of a reply
// then comes from the datapath output registers, while the flag for an unknown letter is on
// the outputs right after that edge. busy stays high through a whole read-all or single read,
// so a new request is taken only once busy is low again; an unknown letter leaves busy low.
// Each value costs a sign step and a digit step per position; characters leave on o_strobe
// and the receiver cannot stall. Reset: synchronous, active low; idle, temp_offset set to 50.
`default_nettype none
module sensor_reply_ascii_formatter_unit
    import sraf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_opcode,
    input  wire logic [7:0]  i_sensor_letter,
    input  wire logic [15:0] i_temp_sample,
    input  wire logic [15:0] i_humidity_sample,
    input  wire logic [15:0] i_co2_sample,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [15:0] i_cfg_data,
    output logic [7:0]       o_out_char,
    output logic             o_last_char,
    output logic             o_bad_letter,
    output logic             o_strobe
);

    t_cmd cmd;

    assign o_cfg_ready = 1'b1;

    sraf_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_opcode        (i_opcode),
        .i_sensor_letter (i_sensor_letter),
        .o_cmd           (cmd),
        .o_busy          (busy)
    );

    sraf_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_cfg_wr          (i_cfg_valid && o_cfg_ready),
        .i_cfg_data        (i_cfg_data),
        .i_temp_sample     (i_temp_sample),
        .i_humidity_sample (i_humidity_sample),
        .i_co2_sample      (i_co2_sample),
        .o_out_char        (o_out_char),
        .o_last_char       (o_last_char),
        .o_bad_letter      (o_bad_letter),
        .o_strobe          (o_strobe)
    );

endmodule
`default_nettype wire

// ===== rtl/sraf_checker.sv =====
`default_nettype none
module sraf_checker
    import sraf_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       i_opcode,
    input wire logic [7:0] i_sensor_letter,
    input wire logic [7:0] o_out_char,
    input wire logic       o_last_char,
    input wire logic       o_bad_letter,
    input wire logic       o_strobe
);

    a_unknown_letter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_opcode && (i_sensor_letter != CH_T)
         && (i_sensor_letter != CH_H) && (i_sensor_letter != CH_C))
        |=> (o_strobe && o_bad_letter && o_last_char && (o_out_char == CH_NUL)))
        else $error("unknown letter transfer not flagged");

    a_read_all_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_opcode) |=> ##1 (o_strobe && (o_out_char == CH_HASH)))
        else $error("read-all reply does not open with hash");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last_char) |-> !busy)
        else $error("busy still high on last character");

    a_quiet_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!busy && !start) |=> !o_strobe)
        else $error("character transfer without a request");

endmodule

bind sensor_reply_ascii_formatter_unit sraf_checker u_sraf_checker (.*);
`default_nettype wire

// ===== verif/sraf_tb_pkg.sv =====
package sraf_tb_pkg;

    typedef enum logic {
        OPC_READ_ALL = 1'b0,
        OPC_READ_ONE = 1'b1
    } t_opcode;

endpackage

// ===== verif/sraf_reply_checker.sv =====
module sraf_reply_checker
    import sraf_pkg::*;
    import sraf_tb_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic        i_busy,
    input  wire logic        i_opcode,
    input  wire logic [7:0]  i_sensor_letter,
    input  wire logic [15:0] i_temp_sample,
    input  wire logic [15:0] i_humidity_sample,
    input  wire logic [15:0] i_co2_sample,
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_ready,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic [7:0]  i_out_char,
    input  wire logic        i_last_char,
    input  wire logic        i_bad_letter,
    input  wire logic        i_strobe,
    output int               o_mismatches,
    output int               o_pending
);

    typedef struct {
        logic [7:0] ch;
        logic       last;
        logic       nosensor;
    } t_reply_char;

    t_reply_char expected_chars[$];
    logic [15:0] offset_copy = TEMP_OFFSET_RESET;
    int          mismatch_count = 0;

    task automatic push_char(input logic [7:0] ch);
        t_reply_char rc;
        rc.ch       = ch;
        rc.last     = 1'b0;
        rc.nosensor = 1'b0;
        expected_chars.push_back(rc);
    endtask

    task automatic push_number(input logic [7:0] sign, input logic [15:0] magnitude);
        logic [7:0]  digits [5];
        logic [15:0] rest;
        int          count;
        rest  = magnitude;
        count = 0;
        push_char(sign);
        do begin
            digits[count] = CH_ZERO + 8'(rest % 16'd10);
            rest          = rest / 16'd10;
            count++;
        end while (rest != 16'd0);
        for (int k = count - 1; k >= 0; k--) begin
            push_char(digits[k]);
        end
    endtask

    task automatic push_temperature(input logic [15:0] raw);
        if (raw <= offset_copy) begin
            push_number(CH_MINUS, offset_copy - raw);
        end else begin
            push_number(CH_PLUS, raw - offset_copy);
        end
    endtask

    task automatic predict_reply(input t_opcode op, input logic [7:0] letter,
                                 input logic [15:0] temp, input logic [15:0] humid,
                                 input logic [15:0] co2);
        t_reply_char bad;
        if (op == OPC_READ_ALL) begin
            push_char(CH_HASH);
            push_char(CH_A);
            push_char(CH_R);
            push_temperature(temp);
            push_number(CH_PLUS, humid);
            push_number(CH_PLUS, co2);
            push_char(CH_BANG);
        end else if (letter == CH_T) begin
            push_temperature(temp);
        end else if (letter == CH_H) begin
            push_number(CH_PLUS, humid);
        end else if (letter == CH_C) begin
            push_number(CH_PLUS, co2);
        end else begin
            bad.ch       = CH_NUL;
            bad.last     = 1'b0;
            bad.nosensor = 1'b1;
            expected_chars.push_back(bad);
        end
        expected_chars[expected_chars.size() - 1].last = 1'b1;
    endtask

    always @(posedge i_clk) begin
        t_reply_char want;
        if (!i_rst_n) begin
            expected_chars.delete();
            offset_copy = TEMP_OFFSET_RESET;
        end else begin
            if (i_strobe) begin
                if (expected_chars.size() == 0) begin
                    if (mismatch_count < 10) begin
                        $display("unexpected char %h last %b bad_letter %b, none outstanding",
                                 i_out_char, i_last_char, i_bad_letter);
                    end
                    mismatch_count++;
                end else begin
                    want = expected_chars.pop_front();
                    if (want.ch !== i_out_char || want.last !== i_last_char ||
                        want.nosensor !== i_bad_letter) begin
                        if (mismatch_count < 10) begin
                            $display("mismatch: expected char %h last %b bad_letter %b, got %h %b %b",
                                     want.ch, want.last, want.nosensor,
                                     i_out_char, i_last_char, i_bad_letter);
                        end
                        mismatch_count++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                offset_copy = i_cfg_data;
            end
            if (i_start && !i_busy) begin
                predict_reply(t_opcode'(i_opcode), i_sensor_letter, i_temp_sample,
                              i_humidity_sample, i_co2_sample);
            end
        end
        o_mismatches <= mismatch_count;
        o_pending    <= expected_chars.size();
    end

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
    import sraf_pkg::*;
    import sraf_tb_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEMS_PER_PHASE = 100;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_opcode = 1'b0;
    logic [7:0]  i_sensor_letter = 8'd0;
    logic [15:0] i_temp_sample = 16'd0;
    logic [15:0] i_humidity_sample = 16'd0;
    logic [15:0] i_co2_sample = 16'd0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data = 16'd0;
    logic [7:0]  o_out_char;
    logic        o_last_char;
    logic        o_bad_letter;
    logic        o_strobe;

    int          mismatches;
    int          pending;
    int          stall_cycles = 0;
    int          sender_idle_pct = 0;
    logic [15:0] cur_offset = TEMP_OFFSET_RESET;

    always #1 i_clk = ~i_clk;

    sensor_reply_ascii_formatter_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_opcode          (i_opcode),
        .i_sensor_letter   (i_sensor_letter),
        .i_temp_sample     (i_temp_sample),
        .i_humidity_sample (i_humidity_sample),
        .i_co2_sample      (i_co2_sample),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data),
        .o_out_char        (o_out_char),
        .o_last_char       (o_last_char),
        .o_bad_letter      (o_bad_letter),
        .o_strobe          (o_strobe)
    );

    sraf_reply_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (start),
        .i_busy            (busy),
        .i_opcode          (i_opcode),
        .i_sensor_letter   (i_sensor_letter),
        .i_temp_sample     (i_temp_sample),
        .i_humidity_sample (i_humidity_sample),
        .i_co2_sample      (i_co2_sample),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data),
        .i_out_char        (o_out_char),
        .i_last_char       (o_last_char),
        .i_bad_letter      (o_bad_letter),
        .i_strobe          (o_strobe),
        .o_mismatches      (mismatches),
        .o_pending         (pending)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("sensor_reply_ascii_formatter_unit test failed");
            $finish;
        end
    end

    // enter and leave at a falling edge
    task automatic send_item(input t_opcode op, input logic [7:0] letter,
                             input logic [15:0] temp, input logic [15:0] humid,
                             input logic [15:0] co2);
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start             <= 1'b1;
        i_opcode          <= op;
        i_sensor_letter   <= letter;
        i_temp_sample     <= temp;
        i_humidity_sample <= humid;
        i_co2_sample      <= co2;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    // hold off until every outstanding character has arrived
    task automatic drain_replies();
        start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_offset(input logic [15:0] value);
        drain_replies();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= 16'($urandom);
        cur_offset = value;
        @(negedge i_clk);
    endtask

    function automatic logic [15:0] pick_sample(input logic [15:0] centre);
        case ($urandom_range(5))
            0:       return 16'($urandom);
            1:       return 16'($urandom_range(9));
            2:       return 16'($urandom_range(999));
            3:       return 16'($urandom_range(65535, 9999));
            4:       return centre + 16'($urandom_range(4)) - 16'd2;
            default: return ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000;
        endcase
    endfunction

    task automatic send_random_item();
        t_opcode    op;
        logic [7:0] letter;
        op = ($urandom_range(9) < 4) ? OPC_READ_ALL : OPC_READ_ONE;
        case ($urandom_range(9))
            0, 1, 2: letter = CH_T;
            3, 4, 5: letter = CH_H;
            6, 7, 8: letter = CH_C;
            default: letter = 8'($urandom);
        endcase
        send_item(op, letter, pick_sample(cur_offset), pick_sample(16'd0), pick_sample(16'd0));
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        sender_idle_pct = 8;
        send_item(OPC_READ_ALL, 8'h58, 16'd50, 16'd0, 16'hFFFF);
        send_item(OPC_READ_ALL, 8'h00, 16'd0, 16'hFFFF, 16'd0);
        send_item(OPC_READ_ALL, CH_T, 16'hFFFF, 16'd12345, 16'd10);
        send_item(OPC_READ_ONE, CH_T, 16'd51, 16'd7, 16'd7);
        send_item(OPC_READ_ONE, CH_T, 16'd49, 16'd7, 16'd7);
        send_item(OPC_READ_ONE, CH_T, 16'd50, 16'd7, 16'd7);
        send_item(OPC_READ_ONE, CH_H, 16'd0, 16'd10000, 16'd0);
        send_item(OPC_READ_ONE, CH_H, 16'd0, 16'd9999, 16'd0);
        send_item(OPC_READ_ONE, CH_C, 16'd0, 16'd0, 16'd1);
        send_item(OPC_READ_ONE, CH_C, 16'd0, 16'd0, 16'd100);
        send_item(OPC_READ_ONE, 8'h74, 16'd1, 16'd2, 16'd3);
        send_item(OPC_READ_ONE, 8'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(OPC_READ_ONE, 8'hFF, 16'd0, 16'd0, 16'd0);
        send_item(OPC_READ_ONE, CH_A, 16'd5, 16'd5, 16'd5);

        write_offset(16'd0);
        send_item(OPC_READ_ONE, CH_T, 16'd0, 16'd0, 16'd0);
        send_item(OPC_READ_ONE, CH_T, 16'hFFFF, 16'd0, 16'd0);
        send_item(OPC_READ_ALL, CH_C, 16'd0, 16'd1, 16'd65000);

        write_offset(16'hFFFF);
        send_item(OPC_READ_ONE, CH_T, 16'hFFFF, 16'd0, 16'd0);
        send_item(OPC_READ_ONE, CH_T, 16'd0, 16'd0, 16'd0);
        send_item(OPC_READ_ALL, CH_H, 16'h8000, 16'h5555, 16'hAAAA);

        for (int phase = 0; phase < 3; phase++) begin
            sender_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 57 : 0;
            case (phase)
                0:       write_offset(16'($urandom));
                1:       write_offset(16'($urandom_range(200)));
                default: write_offset(TEMP_OFFSET_RESET);
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                send_random_item();
                if ($urandom_range(39) == 0) begin
                    drain_replies();
                end
            end
        end

        drain_replies();
        repeat (10) @(negedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("sensor_reply_ascii_formatter_unit test passed");
        end else begin
            $display("sensor_reply_ascii_formatter_unit test failed");
        end
        $finish;
    end

endmodule
